FILE: hdl/hkr_pkg.sv
package hkr_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int BYTE_W    = 2;

   localparam logic [7:0] CAPS_CODE   = 8'h39;
   localparam logic [7:0] TABLE_BASE  = 8'h04;
   localparam logic [7:0] LETTER_LAST = 8'h1d;
   localparam logic [7:0] TABLE_LAST  = 8'h38;
   localparam logic [7:0] GAP_CODE    = 8'h32;
   localparam logic [7:0] ERR_LAST    = 8'h03;
   localparam logic [7:0] ESC_BYTE    = 8'h1b;
   localparam logic [7:0] CSI_BYTE    = 8'h5b;
   localparam logic [7:0] TILDE_BYTE  = 8'h7e;

   localparam logic [7:0] NAV_RIGHT  = 8'h4f;
   localparam logic [7:0] NAV_LEFT   = 8'h50;
   localparam logic [7:0] NAV_DOWN   = 8'h51;
   localparam logic [7:0] NAV_UP     = 8'h52;
   localparam logic [7:0] NAV_HOME   = 8'h4a;
   localparam logic [7:0] NAV_END    = 8'h4d;
   localparam logic [7:0] NAV_DELETE = 8'h4c;

   localparam logic [7:0] CTRL_MASK  = 8'h11;
   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [7:0] ALT_MASK   = 8'h44;

   typedef logic [KEY_SLOTS-1:0][7:0] key_array_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic toggle_caps;
      logic next_slot;
      logic next_byte;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic emits;
      logic caps_new;
      logic slot_last;
      logic byte_last;
   } status_type;

   function automatic logic is_nav(input logic [7:0] code);
      return (code == NAV_RIGHT) || (code == NAV_LEFT) || (code == NAV_DOWN) ||
             (code == NAV_UP) || (code == NAV_HOME) || (code == NAV_END) ||
             (code == NAV_DELETE);
   endfunction

   function automatic logic key_emits(input logic [7:0] code);
      return ((code >= TABLE_BASE) && (code <= TABLE_LAST) && (code != GAP_CODE)) ||
             is_nav(code);
   endfunction

   function automatic logic [7:0] nav_char(input logic [7:0] code);
      logic [7:0] ch;
      case (code)
         NAV_RIGHT:  ch = "C";
         NAV_LEFT:   ch = "D";
         NAV_DOWN:   ch = "B";
         NAV_UP:     ch = "A";
         NAV_HOME:   ch = "H";
         NAV_END:    ch = "F";
         NAV_DELETE: ch = "3";
         default:    ch = 8'h00;
      endcase
      return ch;
   endfunction

   // index of the final byte of a key's sequence
   function automatic logic [BYTE_W-1:0] key_last_idx(input logic [7:0] code,
                                                      input logic alt);
      logic [BYTE_W-1:0] n;
      if (code == NAV_DELETE) begin
         n = BYTE_W'(3);
      end else if (is_nav(code)) begin
         n = BYTE_W'(2);
      end else begin
         n = alt ? BYTE_W'(1) : BYTE_W'(0);
      end
      return n;
   endfunction

   function automatic logic [7:0] table_char(input logic [5:0] idx, input logic upper);
      logic [7:0] ch;
      if (idx < 6'd26) begin
         ch = (upper ? 8'h41 : 8'h61) + {2'b00, idx};
      end else begin
         case (idx)
            6'd26:   ch = upper ? "!" : "1";
            6'd27:   ch = upper ? "@" : "2";
            6'd28:   ch = upper ? "#" : "3";
            6'd29:   ch = upper ? "$" : "4";
            6'd30:   ch = upper ? "%" : "5";
            6'd31:   ch = upper ? "^" : "6";
            6'd32:   ch = upper ? "&" : "7";
            6'd33:   ch = upper ? "*" : "8";
            6'd34:   ch = upper ? "(" : "9";
            6'd35:   ch = upper ? ")" : "0";
            6'd36:   ch = 8'h0d;
            6'd37:   ch = 8'h1b;
            6'd38:   ch = 8'h7f;
            6'd39:   ch = 8'h09;
            6'd40:   ch = 8'h20;
            6'd41:   ch = upper ? "_" : "-";
            6'd42:   ch = upper ? "+" : "=";
            6'd43:   ch = upper ? "{" : "[";
            6'd44:   ch = upper ? "|" : 8'h5c;
            6'd45:   ch = upper ? "|" : 8'h5c;
            6'd47:   ch = upper ? ":" : ";";
            6'd48:   ch = upper ? 8'h22 : 8'h27;
            6'd49:   ch = upper ? "~" : 8'h60;
            6'd50:   ch = upper ? "<" : ",";
            6'd51:   ch = upper ? ">" : ".";
            6'd52:   ch = upper ? "?" : "/";
            default: ch = 8'h00;
         endcase
         if (idx == 6'd44) begin
            ch = upper ? "}" : "]";
         end
      end
      return ch;
   endfunction

   // one byte of the sequence a newly pressed key produces
   function automatic logic [7:0] key_byte(input logic [7:0] code,
                                           input logic [7:0] mods,
                                           input logic caps,
                                           input logic [BYTE_W-1:0] bi);
      logic       shift;
      logic       ctrl;
      logic       alt;
      logic       letter;
      logic [7:0] off;
      logic [7:0] ch;
      logic [7:0] b;
      shift  = (mods & SHIFT_MASK) != 8'h00;
      ctrl   = (mods & CTRL_MASK) != 8'h00;
      alt    = (mods & ALT_MASK) != 8'h00;
      letter = code <= LETTER_LAST;
      off    = code - TABLE_BASE;
      ch     = table_char(off[5:0], shift ^ (letter & caps));
      if (ctrl && letter) begin
         ch = off + 8'd1;
      end
      if (is_nav(code)) begin
         case (bi)
            BYTE_W'(0): b = ESC_BYTE;
            BYTE_W'(1): b = CSI_BYTE;
            BYTE_W'(2): b = nav_char(code);
            default:    b = TILDE_BYTE;
         endcase
      end else if (alt && (bi == BYTE_W'(0))) begin
         b = ESC_BYTE;
      end else begin
         b = ch;
      end
      return b;
   endfunction

endpackage

FILE: hdl/hid_key_report_to_terminal_bytes_core.sv
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_modifiers, req_key_slot_0..5
// rsp_      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_last_of_report
//
// one report transaction is taken while idle; a report holding a rollover or
// error code is dropped with no output
// otherwise the slot scan sequencer steps through the slots in order and
// emits the bytes of each new key, up to 24 output bytes per report
// synchronous active-high reset clears the stored keys and caps lock
// a stalled rsp_ transaction holds its byte; req_stall stays high until
// the current report is done or dropped
module hid_key_report_to_terminal_bytes_core (
   input  logic       clock,
   input  logic       reset,
   // report input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_modifiers,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   // terminal byte output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_report
);
   import hkr_pkg::*;

   key_array_type keys;
   cmd_type       cmd;
   status_type    status;

   // slot order matches the report layout
   assign keys[0] = req_key_slot_0;
   assign keys[1] = req_key_slot_1;
   assign keys[2] = req_key_slot_2;
   assign keys[3] = req_key_slot_3;
   assign keys[4] = req_key_slot_4;
   assign keys[5] = req_key_slot_5;

   // sequencer: accept, scan slots, emit bytes
   hkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // key storage, novelty check, caps lock and byte generation
   hkr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_modifiers      (req_modifiers),
      .req_keys           (keys),
      .cmd                (cmd),
      .status             (status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_report (rsp_last_of_report)
   );

endmodule

FILE: hdl/hkr_ctrl.sv
module hkr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  hkr_pkg::status_type status,
   output hkr_pkg::cmd_type    cmd
);
   import hkr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.err) begin
               state_in = ST_IDLE;
            end else begin
               cmd.toggle_caps = status.caps_new;
               if (status.emits) begin
                  state_in = ST_EMIT;
               end else if (status.slot_last) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.next_slot = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (!status.byte_last) begin
                  cmd.next_byte = 1'b1;
               end else if (status.slot_last) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.next_slot = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input accepted while emitting");

   a_no_commit_on_err: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.err) else $error("dropped report committed");

   a_err_drops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.err) |=> state_ff == ST_IDLE)
      else $error("dropped report not discarded");

endmodule

FILE: hdl/hkr_datapath.sv
module hkr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_modifiers,
   input  hkr_pkg::key_array_type req_keys,
   input  hkr_pkg::cmd_type       cmd,
   output hkr_pkg::status_type    status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_report
);
   import hkr_pkg::*;

   key_array_type         keys_ff;
   key_array_type         prior_ff;
   logic [7:0]            mods_ff;
   logic                  caps_ff;
   logic                  err_ff;
   logic [KEY_SLOTS-1:0]  emit_mask_ff;
   logic [KEY_SLOTS-1:0]  caps_mask_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [BYTE_W-1:0]     byte_ff;

   logic                  err_in;
   logic [KEY_SLOTS-1:0]  emit_mask_in;
   logic [KEY_SLOTS-1:0]  caps_mask_in;
   logic [7:0]            code;
   logic                  later_emit;

   // novelty is judged against the previous report that was not dropped
   always_comb begin
      logic seen;
      err_in       = 1'b0;
      emit_mask_in = '0;
      caps_mask_in = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         seen = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            seen = seen | (prior_ff[j] == req_keys[i]);
         end
         if ((req_keys[i] != 8'h00) && (req_keys[i] <= ERR_LAST)) begin
            err_in = 1'b1;
         end
         emit_mask_in[i] = (req_keys[i] != 8'h00) && !seen && key_emits(req_keys[i]);
         caps_mask_in[i] = !seen && (req_keys[i] == CAPS_CODE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         caps_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            prior_ff <= keys_ff;
         end
         if (cmd.toggle_caps) begin
            caps_ff <= !caps_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         keys_ff      <= req_keys;
         mods_ff      <= req_modifiers;
         err_ff       <= err_in;
         emit_mask_ff <= emit_mask_in;
         caps_mask_ff <= caps_mask_in;
         slot_ff      <= '0;
         byte_ff      <= '0;
      end else if (cmd.next_slot) begin
         slot_ff <= slot_ff + SLOT_W'(1);
         byte_ff <= '0;
      end else if (cmd.next_byte) begin
         byte_ff <= byte_ff + BYTE_W'(1);
      end
   end

   assign code = keys_ff[slot_ff];

   always_comb begin
      later_emit = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if ((i > int'(slot_ff)) && emit_mask_ff[i]) begin
            later_emit = 1'b1;
         end
      end
   end

   assign status.err       = err_ff;
   assign status.emits     = emit_mask_ff[slot_ff];
   assign status.caps_new  = caps_mask_ff[slot_ff];
   assign status.slot_last = slot_ff == SLOT_W'(KEY_SLOTS - 1);
   assign status.byte_last =
      byte_ff == key_last_idx(code, (mods_ff & ALT_MASK) != 8'h00);

   assign rsp_out_byte       = key_byte(code, mods_ff, caps_ff, byte_ff);
   assign rsp_last_of_report = status.byte_last && !later_emit;

   a_prior_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.commit) && !$past(reset) |-> $stable(prior_ff))
      else $error("stored keys changed without commit");

   a_caps_only_on_toggle: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.toggle_caps) && !$past(reset) |-> $stable(caps_ff))
      else $error("caps lock changed without toggle");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.next_slot |-> !status.slot_last)
      else $error("slot stepped past the last slot");

endmodule

FILE: sim/hkr_checker.sv
module hkr_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_modifiers,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_of_report,
   output int         fail_count,
   output int         bytes_due,
   output int         bytes_seen,
   output int         reports_taken,
   output int         reports_dropped
);
   import hkr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } term_byte_type;

   term_byte_type term_bytes_due[$];
   key_array_type held_keys;
   logic          caps_state;

   // layout character for table index idx (code - 0x04)
   function automatic logic [7:0] keymap_char(input logic [5:0] idx, input logic upper);
      logic [7:0] ch;
      if (idx < 6'd26) begin
         ch = (upper ? 8'h41 : 8'h61) + 8'(idx);
      end else begin
         case (idx)
            6'd26:   ch = upper ? "!" : "1";
            6'd27:   ch = upper ? "@" : "2";
            6'd28:   ch = upper ? "#" : "3";
            6'd29:   ch = upper ? "$" : "4";
            6'd30:   ch = upper ? "%" : "5";
            6'd31:   ch = upper ? "^" : "6";
            6'd32:   ch = upper ? "&" : "7";
            6'd33:   ch = upper ? "*" : "8";
            6'd34:   ch = upper ? "(" : "9";
            6'd35:   ch = upper ? ")" : "0";
            6'd36:   ch = 8'h0d;
            6'd37:   ch = 8'h1b;
            6'd38:   ch = 8'h7f;
            6'd39:   ch = 8'h09;
            6'd40:   ch = 8'h20;
            6'd41:   ch = upper ? "_" : "-";
            6'd42:   ch = upper ? "+" : "=";
            6'd43:   ch = upper ? "{" : "[";
            6'd44:   ch = upper ? "}" : "]";
            6'd45:   ch = upper ? 8'h7c : 8'h5c;
            6'd47:   ch = upper ? ":" : ";";
            6'd48:   ch = upper ? 8'h22 : 8'h27;
            6'd49:   ch = upper ? "~" : 8'h60;
            6'd50:   ch = upper ? "<" : ",";
            6'd51:   ch = upper ? ">" : ".";
            6'd52:   ch = upper ? "?" : "/";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   // turn one accepted report into the terminal bytes it should produce
   task automatic expand_report(input logic [7:0] mods, input key_array_type keys);
      logic       shift;
      logic       ctrl;
      logic       alt;
      logic       letter;
      logic       upper;
      logic       rejected;
      logic       seen;
      logic [7:0] code;
      logic [7:0] ch;
      logic [7:0] nav;
      logic [7:0] seq[$];
      term_byte_type entry;
      shift    = (mods & SHIFT_MASK) != 8'h00;
      ctrl     = (mods & CTRL_MASK) != 8'h00;
      alt      = (mods & ALT_MASK) != 8'h00;
      rejected = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (keys[i] >= 8'd1 && keys[i] <= ERR_LAST) rejected = 1'b1;
      end
      if (rejected) begin
         reports_dropped++;
         return;
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         code = keys[i];
         seen = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (held_keys[j] == code) seen = 1'b1;
         end
         if (code != 8'h00 && !seen) begin
            if (code == CAPS_CODE) begin
               caps_state = ~caps_state;
            end else if (code >= TABLE_BASE && code <= TABLE_LAST) begin
               letter = code <= LETTER_LAST;
               upper  = shift ^ (letter & caps_state);
               ch     = keymap_char(6'(code - TABLE_BASE), upper);
               if (ctrl && letter) ch = code - TABLE_BASE + 8'd1;
               if (ch != 8'h00) begin
                  if (alt) seq.push_back(ESC_BYTE);
                  seq.push_back(ch);
               end
            end else begin
               case (code)
                  NAV_RIGHT:  nav = "C";
                  NAV_LEFT:   nav = "D";
                  NAV_DOWN:   nav = "B";
                  NAV_UP:     nav = "A";
                  NAV_HOME:   nav = "H";
                  NAV_END:    nav = "F";
                  NAV_DELETE: nav = "3";
                  default:    nav = 8'h00;
               endcase
               if (nav != 8'h00) begin
                  seq.push_back(ESC_BYTE);
                  seq.push_back(CSI_BYTE);
                  seq.push_back(nav);
                  if (code == NAV_DELETE) seq.push_back(TILDE_BYTE);
               end
            end
         end
      end
      held_keys = keys;
      for (int k = 0; k < seq.size(); k++) begin
         entry.data = seq[k];
         entry.last = (k == seq.size() - 1);
         term_bytes_due.push_back(entry);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("checker: %s, got %02h expected %02h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      term_byte_type want;
      if (reset) begin
         held_keys  = '0;
         caps_state = 1'b0;
         term_bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (term_bytes_due.size() == 0) begin
               report_mismatch("terminal byte with nothing pending", rsp_out_byte, 8'h00);
            end else begin
               want = term_bytes_due.pop_front();
               if (rsp_out_byte != want.data) begin
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               end
               if (rsp_last_of_report != want.last) begin
                  report_mismatch("last_of_report", 8'(rsp_last_of_report), 8'(want.last));
               end
               bytes_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            reports_taken++;
            expand_report(req_modifiers, {req_key_slot_5, req_key_slot_4, req_key_slot_3,
                                          req_key_slot_2, req_key_slot_1, req_key_slot_0});
         end
      end
      bytes_due = term_bytes_due.size();
   end

endmodule

FILE: sim/tb.sv
module tb;

   import hkr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // the limit allows for the longest reports plus stalls and gaps,
   // so this is many times what a correct run needs
   localparam int CYCLE_LIMIT = 200000;
   localparam int CLEAN_ITEMS = 220;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_modifiers = 8'h00;
   logic [7:0] req_key_slot_0 = 8'h00;
   logic [7:0] req_key_slot_1 = 8'h00;
   logic [7:0] req_key_slot_2 = 8'h00;
   logic [7:0] req_key_slot_3 = 8'h00;
   logic [7:0] req_key_slot_4 = 8'h00;
   logic [7:0] req_key_slot_5 = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_report;

   int         fail_count;
   int         bytes_due;
   int         bytes_seen;
   int         reports_taken;
   int         reports_dropped;
   int         cycle_count = 0;
   // high during the stretch where neither side idles
   logic       calm = 1'b0;

   always #1ns clock = ~clock;

   hid_key_report_to_terminal_bytes_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_modifiers      (req_modifiers),
      .req_key_slot_0     (req_key_slot_0),
      .req_key_slot_1     (req_key_slot_1),
      .req_key_slot_2     (req_key_slot_2),
      .req_key_slot_3     (req_key_slot_3),
      .req_key_slot_4     (req_key_slot_4),
      .req_key_slot_5     (req_key_slot_5),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_report (rsp_last_of_report)
   );

   hkr_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_modifiers      (req_modifiers),
      .req_key_slot_0     (req_key_slot_0),
      .req_key_slot_1     (req_key_slot_1),
      .req_key_slot_2     (req_key_slot_2),
      .req_key_slot_3     (req_key_slot_3),
      .req_key_slot_4     (req_key_slot_4),
      .req_key_slot_5     (req_key_slot_5),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_report (rsp_last_of_report),
      .fail_count         (fail_count),
      .bytes_due          (bytes_due),
      .bytes_seen         (bytes_seen),
      .reports_taken      (reports_taken),
      .reports_dropped    (reports_dropped)
   );

   // terminal side: stalls at random about 16 percent of the time, never during the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 16);
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: watchdog expired after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // slot list in natural order, slot 0 first
   function automatic key_array_type slots(input logic [7:0] k0, input logic [7:0] k1,
                                           input logic [7:0] k2, input logic [7:0] k3,
                                           input logic [7:0] k4, input logic [7:0] k5);
      return {k5, k4, k3, k2, k1, k0};
   endfunction

   // present one report transaction and hold it until the block takes it
   task automatic send_report(input logic [7:0] mods, input key_array_type keys);
      // optional idle gap first; valid drops in this step and rises in a later one
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_modifiers  <= mods;
      req_key_slot_0 <= keys[0];
      req_key_slot_1 <= keys[1];
      req_key_slot_2 <= keys[2];
      req_key_slot_3 <= keys[3];
      req_key_slot_4 <= keys[4];
      req_key_slot_5 <= keys[5];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      key_array_type keys;
      key_array_type last_keys;
      logic [7:0]    mods;
      logic          is_err;
      int            clean_sent;
      int            r;
      int            waited;
      int            errors;
      last_keys  = '0;
      clean_sent = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed reports ----
      // empty report, then a plain letter
      send_report(8'h00, slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(8'h00, slots(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // right shift on the last letter
      send_report(8'h20, slots(8'h1d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // ctrl with a letter gives a control code
      send_report(8'h01, slots(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // alt prefixes escape
      send_report(8'h44, slots(8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // caps lock on, emits nothing; then a letter comes out upper case
      send_report(8'h00, slots(8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(8'h00, slots(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // shift with caps lock cancels for letters, but not for digits
      send_report(8'h02, slots(8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(8'h02, slots(8'h1e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(8'h00, slots(8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // hole in the table with alt: nothing at all
      send_report(8'h04, slots(8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // ctrl with a non-letter is ignored
      send_report(8'h11, slots(8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // six navigation keys at once
      send_report(8'h00, slots(8'h4f, 8'h50, 8'h51, 8'h52, 8'h4a, 8'h4d));
      // alt with delete: no extra escape
      send_report(8'h44, slots(8'h4c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // rollover and error reports are dropped whole
      send_report(8'h00, slots(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
      send_report(8'h00, slots(8'h04, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(8'h00, slots(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03));
      // same new code in three slots, then a held key beside a new one
      send_report(8'h00, slots(8'h08, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00));
      send_report(8'h00, slots(8'h08, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00));
      // longest output: six deletes
      send_report(8'h00, slots(8'h4c, 8'h4c, 8'h4c, 8'h4c, 8'h4c, 8'h4c));
      // unmapped codes with every modifier bit set
      send_report(8'hff, slots(8'he0, 8'he7, 8'hff, 8'h3a, 8'h00, 8'h00));
      send_report(8'hff, slots(8'h04, 8'h05, 8'h1d, 8'h1e, 8'h38, 8'h28));
      // ignored modifier bits only
      send_report(8'h88, slots(8'h2c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // shifted punctuation up to the end of the table
      send_report(8'h22, slots(8'h38, 8'h37, 8'h36, 8'h35, 8'h34, 8'h33));
      send_report(8'h00, slots(8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d));
      last_keys = slots(8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d);

      // ---- random typing ----
      while (clean_sent < CLEAN_ITEMS) begin
         calm = (clean_sent >= 120) && (clean_sent < 175);

         r = $urandom_range(99);
         if (r < 40) begin
            mods = 8'h00;
         end else if (r < 60) begin
            mods = 8'h01 << $urandom_range(7);
         end else begin
            mods = 8'($urandom_range(255));
         end

         // mostly plausible key sets: some keys held from the last report
         for (int i = 0; i < KEY_SLOTS; i++) begin
            r = $urandom_range(99);
            if (r < 25) begin
               keys[i] = last_keys[$urandom_range(KEY_SLOTS - 1)];
            end else if (r < 45) begin
               keys[i] = 8'h00;
            end else if (r < 75) begin
               keys[i] = 8'($urandom_range(TABLE_BASE, LETTER_LAST));
            end else if (r < 85) begin
               keys[i] = 8'($urandom_range(LETTER_LAST + 1, TABLE_LAST));
            end else if (r < 91) begin
               case ($urandom_range(6))
                  0:       keys[i] = NAV_RIGHT;
                  1:       keys[i] = NAV_LEFT;
                  2:       keys[i] = NAV_DOWN;
                  3:       keys[i] = NAV_UP;
                  4:       keys[i] = NAV_HOME;
                  5:       keys[i] = NAV_END;
                  default: keys[i] = NAV_DELETE;
               endcase
            end else if (r < 94) begin
               keys[i] = CAPS_CODE;
            end else begin
               keys[i] = 8'($urandom_range(CAPS_CODE + 1, 255));
            end
         end

         r = $urandom_range(99);
         if (r < 4) begin
            // rollover: every slot reports the phantom code
            keys = {KEY_SLOTS{8'h01}};
         end else if (r < 9) begin
            // error code in one slot among otherwise normal keys
            keys[$urandom_range(KEY_SLOTS - 1)] = 8'($urandom_range(1, ERR_LAST));
         end else if (r < 15) begin
            // noise: any byte in any slot
            for (int i = 0; i < KEY_SLOTS; i++) keys[i] = 8'($urandom_range(255));
         end

         is_err = 1'b0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            if (keys[i] >= 8'd1 && keys[i] <= ERR_LAST) is_err = 1'b1;
         end

         send_report(mods, keys);
         if (!is_err) begin
            clean_sent++;
            last_keys = keys;
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain: wait for every pending byte, bounded, then watch for strays
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (bytes_due != 0 && waited < 5000);
      repeat (40) @(posedge clock);
      @(negedge clock);

      if (bytes_due != 0) begin
         $display("tb: %0d terminal bytes never arrived", bytes_due);
      end
      errors = fail_count + bytes_due;
      $display("tb: %0d reports taken, %0d of them dropped for rollover or error codes",
               reports_taken, reports_dropped);
      $display("tb: %0d terminal bytes compared, %0d mismatches", bytes_seen, fail_count);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/hkr_pkg.sv
hdl/hkr_ctrl.sv
hdl/hkr_datapath.sv
hdl/hid_key_report_to_terminal_bytes_core.sv
sim/hkr_checker.sv
sim/tb.sv
